>>> rtl/core/dtpy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpy_pkg
// Shared widths, angle constants, pipeline payload types and the CORDIC
// arctangent table for the direction to pitch/yaw core.
// ----------------------------------------------------------------------------
package dtpy_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned FRAC_W     = 24;
  // Holds every x and y value of both vectoring passes with a spare bit.
  localparam int unsigned DATA_W     = 62;
  // Angle accumulator, degrees with FRAC_W fraction bits.
  localparam int unsigned ANG_W      = 36;
  // Angle after rounding to Q8.8, before wrapping and clamping.
  localparam int unsigned RND_W      = ANG_W - 16;
  localparam int unsigned GAIN_W     = 26;
  localparam int unsigned MUL_W      = DIFF_W + GAIN_W;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned YAW_W      = 17;
  localparam int unsigned IN_TDATA_W  = 6 * COORD_W;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned MAX_STEPS  = 62;

  // Negated CORDIC gain in Q24, so that the product is already -dz * K.
  localparam logic signed [GAIN_W-1:0] NEG_GAIN_Q24 = -26'sd27628053;
  localparam logic signed [ANG_W-1:0]  DEG180_Q24   = 36'sd3019898880;
  localparam logic signed [ANG_W-1:0]  ROUND_HALF   = 36'sd32768;
  localparam logic signed [RND_W-1:0]  DEG90_Q88    = 20'sd23040;
  localparam logic signed [RND_W-1:0]  DEG180_Q88   = 20'sd46080;
  localparam logic signed [RND_W-1:0]  DEG360_Q88   = 20'sd92160;
  localparam logic [63:0]              RAD_DEG_Q24  = 64'd961263669;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [16] = '{
    36'sd754974720, 36'sd445687602, 36'sd235489088, 36'sd119537938,
    36'sd60000934,  36'sd30029717,  36'sd15018523,  36'sd7509720,
    36'sd3754917,   36'sd1877466,   36'sd938734,    36'sd469367,
    36'sd234684,    36'sd117342,    36'sd58671,     36'sd29335
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } cordic_vec_t;

  // Carried alongside the yaw pass.
  typedef struct packed {
    logic signed [DATA_W-1:0] pitch_y;
    logic                     zero_xy;
    logic                     dz_pos;
    logic                     yaw_half;
  } yaw_side_t;

  // Carried alongside the pitch pass.
  typedef struct packed {
    logic signed [YAW_W-1:0] yaw;
    logic                    zero_xy;
    logic                    dz_pos;
  } pitch_side_t;

  // atan(2^-i) in degrees, Q24; small angles use 2^-i * 180/pi rounded.
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic [63:0] v;
    v = '0;
    if (i < 16) begin
      return ATAN_TAB[i[3:0]];
    end else if (i >= 63) begin
      return '0;
    end else begin
      v = (RAD_DEG_Q24 + (64'd1 << (i - 1))) >> i;
      return ANG_W'(v);
    end
  endfunction

endpackage

>>> rtl/core/dtpy_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpy_cordic_stage
// One registered vectoring CORDIC iteration with a fixed shift, carrying an
// opaque sideband word along with the vector.
// ----------------------------------------------------------------------------
module dtpy_cordic_stage #(
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  dtpy_pkg::cordic_vec_t vec_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output dtpy_pkg::cordic_vec_t vec_o,
  output logic [SIDE_W-1:0]    side_o
);
  import dtpy_pkg::*;

  localparam logic signed [ANG_W-1:0] ANGLE = atan_step(STEP);

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  cordic_vec_t              vec_d;
  cordic_vec_t              vec_q;
  logic [SIDE_W-1:0]        side_q;
  logic                     valid_q;

  assign xs = vec_i.x >>> STEP;
  assign ys = vec_i.y >>> STEP;

  always_comb begin
    if (!vec_i.y[DATA_W-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ANGLE;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      vec_q  <= vec_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/dtpy_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpy_prep
// Two front stages: the difference vector, then the start vector of the yaw
// pass (folded into the right half plane), the scaled pitch ordinate and the
// special-case flags.
// ----------------------------------------------------------------------------
module dtpy_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [dtpy_pkg::IN_TDATA_W-1:0]     tdata_i,
  output logic                                valid_o,
  output dtpy_pkg::cordic_vec_t               vec_o,
  output dtpy_pkg::yaw_side_t                 side_o
);
  import dtpy_pkg::*;

  logic signed [COORD_W-1:0] start_x, start_y, start_z;
  logic signed [COORD_W-1:0] end_x, end_y, end_z;
  logic signed [DIFF_W-1:0]  dx_d, dy_d, dz_d;
  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q;
  logic                      diff_valid_q;

  logic signed [DATA_W-1:0]  x_sc, y_sc;
  logic signed [MUL_W-1:0]   prod;
  logic                      left_half;
  cordic_vec_t               vec_d, vec_q;
  yaw_side_t                 side_d, side_q;
  logic                      valid_q;

  assign start_x = tdata_i[0*COORD_W +: COORD_W];
  assign start_y = tdata_i[1*COORD_W +: COORD_W];
  assign start_z = tdata_i[2*COORD_W +: COORD_W];
  assign end_x   = tdata_i[3*COORD_W +: COORD_W];
  assign end_y   = tdata_i[4*COORD_W +: COORD_W];
  assign end_z   = tdata_i[5*COORD_W +: COORD_W];

  assign dx_d = DIFF_W'(end_x) - DIFF_W'(start_x);
  assign dy_d = DIFF_W'(end_y) - DIFF_W'(start_y);
  assign dz_d = DIFF_W'(end_z) - DIFF_W'(start_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (en_i) begin
      diff_valid_q <= valid_i;
      valid_q      <= diff_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
  end

  assign x_sc      = DATA_W'(dx_q) <<< FRAC_W;
  assign y_sc      = DATA_W'(dy_q) <<< FRAC_W;
  assign left_half = dx_q[DIFF_W-1];
  assign prod      = MUL_W'(dz_q) * MUL_W'(NEG_GAIN_Q24);

  always_comb begin
    // Vectors in the left half plane are turned by 180 degrees first.
    if (left_half) begin
      vec_d.x = -x_sc;
      vec_d.y = -y_sc;
      vec_d.z = dy_q[DIFF_W-1] ? -DEG180_Q24 : DEG180_Q24;
    end else begin
      vec_d.x = x_sc;
      vec_d.y = y_sc;
      vec_d.z = '0;
    end
    side_d.pitch_y  = DATA_W'(prod);
    side_d.zero_xy  = (dx_q == '0) && (dy_q == '0);
    side_d.dz_pos   = !dz_q[DIFF_W-1] && (dz_q != '0);
    side_d.yaw_half = (dy_q == '0) && left_half;
  end

  always_ff @(posedge clk_i) begin
    if (en_i && diff_valid_q) begin
      vec_q  <= vec_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/dtpy_yaw_fix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpy_yaw_fix
// Rounds the yaw accumulator to Q8.8, wraps and clamps it to +-180 degrees,
// and loads the pitch pass with the planar length and the scaled -dz.
// ----------------------------------------------------------------------------
module dtpy_yaw_fix (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dtpy_pkg::cordic_vec_t  vec_i,
  input  dtpy_pkg::yaw_side_t    side_i,
  output logic                   valid_o,
  output dtpy_pkg::cordic_vec_t  vec_o,
  output dtpy_pkg::pitch_side_t  side_o
);
  import dtpy_pkg::*;

  logic signed [ANG_W-1:0] sum;
  logic signed [RND_W-1:0] rnd;
  logic signed [RND_W-1:0] wrap;
  cordic_vec_t             vec_d, vec_q;
  pitch_side_t             side_d, side_q;
  logic                    valid_q;

  assign sum = vec_i.z + ROUND_HALF;

  always_comb begin
    rnd = sum[ANG_W-1:16];
    if (side_i.yaw_half) begin
      rnd = DEG180_Q88;
    end
    wrap = rnd;
    if (wrap > DEG180_Q88) begin
      wrap = wrap - DEG360_Q88;
    end
    if (wrap < -DEG180_Q88) begin
      wrap = wrap + DEG360_Q88;
    end
    if (wrap > DEG180_Q88) begin
      wrap = DEG180_Q88;
    end
    if (wrap < -DEG180_Q88) begin
      wrap = -DEG180_Q88;
    end

    vec_d.x = vec_i.x;
    vec_d.y = side_i.pitch_y;
    vec_d.z = '0;
    side_d.yaw     = side_i.zero_xy ? '0 : YAW_W'(wrap);
    side_d.zero_xy = side_i.zero_xy;
    side_d.dz_pos  = side_i.dz_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      vec_q  <= vec_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/direction_to_pitch_yaw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_pitch_yaw_core
// Aim angles from a start point toward an end point: yaw and pitch in Q8.8
// degrees from two unrolled vectoring CORDIC passes.
// ----------------------------------------------------------------------------
// The core accepts one point pair per clock cycle while s_axis_tready is
// high and returns one result per pair, in order. The pipeline holds two
// front stages, one register per CORDIC iteration for the yaw pass, one yaw
// rounding stage, one register per iteration for the pitch pass and the
// output register. A result waiting at the output stops the pipeline only
// once its last stage is occupied; empty slots still fill.
module direction_to_pitch_yaw_core #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
  input  logic [dtpy_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pitch_angle [15:0], yaw_angle [32:16], zero fill [39:33]
  output logic [dtpy_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dtpy_pkg::*;

  localparam int unsigned NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned YSW    = $bits(yaw_side_t);
  localparam int unsigned PSW    = $bits(pitch_side_t);

  logic              en_out;
  logic              en_pipe;

  cordic_vec_t       yaw_vec  [NSTEPS+1];
  logic [YSW-1:0]    yaw_sd   [NSTEPS+1];
  logic [NSTEPS:0]   yaw_v;
  yaw_side_t         prep_side;
  yaw_side_t         yaw_last_side;

  cordic_vec_t       pit_vec  [NSTEPS+1];
  logic [PSW-1:0]    pit_sd   [NSTEPS+1];
  logic [NSTEPS:0]   pit_v;
  pitch_side_t       fix_side;
  pitch_side_t       pit_last_side;

  logic signed [ANG_W-1:0]   p_sum;
  logic signed [RND_W-1:0]   p_rnd;
  logic signed [RND_W-1:0]   p_clamp;
  logic [OUT_TDATA_W-1:0]    out_d;
  logic [OUT_TDATA_W-1:0]    out_q;
  logic                      out_valid_q;

  assign en_out        = !out_valid_q || m_axis_tready;
  assign en_pipe       = en_out || !pit_v[NSTEPS];
  assign s_axis_tready = en_pipe;

  dtpy_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_pipe),
    .valid_i (s_axis_tvalid),
    .tdata_i (s_axis_tdata),
    .valid_o (yaw_v[0]),
    .vec_o   (yaw_vec[0]),
    .side_o  (prep_side)
  );

  assign yaw_sd[0] = prep_side;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_yaw
    dtpy_cordic_stage #(
      .STEP   (i),
      .SIDE_W (YSW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_pipe),
      .valid_i (yaw_v[i]),
      .vec_i   (yaw_vec[i]),
      .side_i  (yaw_sd[i]),
      .valid_o (yaw_v[i+1]),
      .vec_o   (yaw_vec[i+1]),
      .side_o  (yaw_sd[i+1])
    );
  end

  assign yaw_last_side = yaw_sd[NSTEPS];

  dtpy_yaw_fix u_yaw_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_pipe),
    .valid_i (yaw_v[NSTEPS]),
    .vec_i   (yaw_vec[NSTEPS]),
    .side_i  (yaw_last_side),
    .valid_o (pit_v[0]),
    .vec_o   (pit_vec[0]),
    .side_o  (fix_side)
  );

  assign pit_sd[0] = fix_side;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_pitch
    dtpy_cordic_stage #(
      .STEP   (i),
      .SIDE_W (PSW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_pipe),
      .valid_i (pit_v[i]),
      .vec_i   (pit_vec[i]),
      .side_i  (pit_sd[i]),
      .valid_o (pit_v[i+1]),
      .vec_o   (pit_vec[i+1]),
      .side_o  (pit_sd[i+1])
    );
  end

  assign pit_last_side = pit_sd[NSTEPS];
  assign p_sum         = pit_vec[NSTEPS].z + ROUND_HALF;
  assign p_rnd         = p_sum[ANG_W-1:16];

  always_comb begin
    p_clamp = p_rnd;
    if (p_clamp > DEG90_Q88) begin
      p_clamp = DEG90_Q88;
    end
    if (p_clamp < -DEG90_Q88) begin
      p_clamp = -DEG90_Q88;
    end
    // A vertical direction has no azimuth: pitch is straight up or down.
    if (pit_last_side.zero_xy) begin
      p_clamp = pit_last_side.dz_pos ? -DEG90_Q88 : DEG90_Q88;
    end
    out_d = '0;
    out_d[PITCH_W-1:0]             = PITCH_W'(p_clamp);
    out_d[PITCH_W +: YAW_W]        = pit_last_side.yaw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= pit_v[NSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && pit_v[NSTEPS]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A result held at the output must not let the last stage be overwritten.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && pit_v[NSTEPS]) |=> pit_v[NSTEPS])
    else $error("last pipeline stage lost an item during an output stall");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[PITCH_W-1:0]) <= 16'sd23040 &&
                       $signed(m_axis_tdata[PITCH_W-1:0]) >= -16'sd23040))
    else $error("pitch outside +-90 degrees");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[PITCH_W +: YAW_W]) <= 17'sd46080 &&
                       $signed(m_axis_tdata[PITCH_W +: YAW_W]) >= -17'sd46080))
    else $error("yaw outside +-180 degrees");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:PITCH_W+YAW_W] == '0))
    else $error("output fill bits not zero");

endmodule
